@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the PES header generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition never holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

@@ rtl/core/phg_pkg.sv @@
// ----------------------------------------------------------------------------
// PES header generator package
// Types, constants and helper functions shared by the header generator.
// ----------------------------------------------------------------------------
package phg_pkg;

	localparam int MAX_HEADER_BYTES = 64;
	localparam int QUEUE_DEPTH_DEF  = 2;

	localparam int POS_W   = 6;
	localparam int TOTAL_W = 7;
	localparam int LEN_W   = 16;
	localparam int TS_W    = 33;
	localparam int SIZE_W  = 24;
	localparam int FIXED_W = 6;
	localparam int OPT_W   = 3;
	localparam int BYTE_W  = 8;
	localparam int CFG_IDX_W = 3;

	localparam logic [TOTAL_W-1:0] SHORT_TOTAL = 7'd6;
	localparam logic [TOTAL_W-1:0] FULL_BASE   = 7'd9;
	localparam logic [TOTAL_W-1:0] STAMP_LEN   = 7'd5;
	localparam logic [TOTAL_W-1:0] EXT_LEN     = 7'd3;
	localparam logic [TOTAL_W-1:0] MAX_TOTAL   = TOTAL_W'(MAX_HEADER_BYTES);

	localparam logic [BYTE_W-1:0] START_BYTE0 = 8'h00;
	localparam logic [BYTE_W-1:0] START_BYTE1 = 8'h00;
	localparam logic [BYTE_W-1:0] START_BYTE2 = 8'h01;
	localparam logic [BYTE_W-1:0] FLAG1_BASE  = 8'h81;
	localparam logic [BYTE_W-1:0] FLAG1_ALIGN = 8'h04;
	localparam logic [BYTE_W-1:0] FLAGS_BOTH  = 8'hC0;
	localparam logic [BYTE_W-1:0] FLAGS_PTS   = 8'h80;
	localparam logic [BYTE_W-1:0] FLAGS_EXT   = 8'h01;
	localparam logic [BYTE_W-1:0] EXT_BYTE0   = 8'h0F;
	localparam logic [BYTE_W-1:0] EXT_BYTE1   = 8'h81;
	localparam logic [BYTE_W-1:0] PAD_BYTE    = 8'hFF;

	localparam logic [3:0] PREFIX_PTS_ONLY = 4'h2;
	localparam logic [3:0] PREFIX_PTS      = 4'h3;
	localparam logic [3:0] PREFIX_DTS      = 4'h1;

	localparam logic [CFG_IDX_W-1:0] CFG_SID          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_OPTS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXT_SID      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_LENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IS_VIDEO     = 3'd4;

	localparam int OPT_FULL  = 0;
	localparam int OPT_ALIGN = 1;
	localparam int OPT_EXT   = 2;

	typedef enum logic [1:0] {
		TS_NONE = 2'd0,
		TS_PTS  = 2'd1,
		TS_BOTH = 2'd2
	} ts_mode_t;

	typedef struct packed {
		logic [LEN_W-1:0]   length_field;
		logic [TOTAL_W-1:0] total;
		ts_mode_t           ts_mode;
		logic               full;
		logic               align;
		logic               ext;
		logic [TS_W-1:0]    pts;
		logic [TS_W-1:0]    dts;
	} phg_desc_t;

	function automatic logic [BYTE_W-1:0] stamp_byte(input logic [3:0] prefix,
			input logic [TS_W-1:0] ts, input logic [2:0] k);
		logic [BYTE_W-1:0] b;
		unique case (k)
			3'd0: b = {prefix, ts[32:30], 1'b1};
			3'd1: b = ts[29:22];
			3'd2: b = {ts[21:15], 1'b1};
			3'd3: b = ts[14:7];
			3'd4: b = {ts[6:0], 1'b1};
			default: b = PAD_BYTE;
		endcase
		return b;
	endfunction

endpackage

@@ rtl/core/phg_front.sv @@
// ----------------------------------------------------------------------------
// PES header generator front end
// Accepts header requests and classifies them into a header descriptor.
// ----------------------------------------------------------------------------
module phg_front (
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [phg_pkg::SIZE_W-1:0]     payload_size,
	input  logic [phg_pkg::TS_W-1:0]       pts,
	input  logic                           pts_valid,
	input  logic [phg_pkg::TS_W-1:0]       dts,
	input  logic                           dts_valid,
	input  logic [phg_pkg::OPT_W-1:0]      header_options,
	input  logic [phg_pkg::FIXED_W-1:0]    fixed_header_length,
	input  logic                           is_video,
	input  logic                           queue_full,
	output logic                           push,
	output phg_pkg::phg_desc_t             desc
);
	import phg_pkg::*;

	ts_mode_t              mode;
	logic [TOTAL_W-1:0]    natural_total;
	logic [TOTAL_W-1:0]    fixed_total;
	logic [TOTAL_W-1:0]    total;
	logic [SIZE_W:0]       length_sum;
	logic                  full;
	logic                  ext;

	assign full = header_options[OPT_FULL];
	assign ext  = header_options[OPT_EXT];

	always_comb begin
		if (pts_valid && dts_valid && (pts != dts)) begin
			mode = TS_BOTH;
		end else if (pts_valid) begin
			mode = TS_PTS;
		end else begin
			mode = TS_NONE;
		end
	end

	always_comb begin
		natural_total = FULL_BASE;
		unique case (mode)
			TS_BOTH: natural_total = FULL_BASE + STAMP_LEN + STAMP_LEN;
			TS_PTS:  natural_total = FULL_BASE + STAMP_LEN;
			default: natural_total = FULL_BASE;
		endcase
		if (ext) begin
			natural_total = natural_total + EXT_LEN;
		end
		fixed_total = TOTAL_W'(fixed_header_length) + FULL_BASE;
		if (!full) begin
			total = SHORT_TOTAL;
		end else if ((fixed_header_length != '0) && (natural_total <= fixed_total)) begin
			total = (fixed_total > MAX_TOTAL) ? MAX_TOTAL : fixed_total;
		end else begin
			total = natural_total;
		end
	end

	assign length_sum = (SIZE_W+1)'(payload_size) + (SIZE_W+1)'(total)
		- (SIZE_W+1)'(SHORT_TOTAL);

	always_comb begin
		desc.total   = total;
		desc.ts_mode = mode;
		desc.full    = full;
		desc.align   = header_options[OPT_ALIGN];
		desc.ext     = ext;
		desc.pts     = pts;
		desc.dts     = dts;
		if ((payload_size == '0) || (is_video && (length_sum > (SIZE_W+1)'(16'hFFFF)))) begin
			desc.length_field = '0;
		end else begin
			desc.length_field = length_sum[LEN_W-1:0];
		end
	end

	assign req_stall = queue_full;
	assign push      = req_valid && !queue_full;

endmodule

@@ rtl/core/phg_queue.sv @@
// ----------------------------------------------------------------------------
// PES header generator descriptor queue
// Short show-ahead queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module phg_queue #(
	parameter int DEPTH = phg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  phg_pkg::phg_desc_t push_desc,
	output logic               full,
	input  logic               pop,
	output phg_pkg::phg_desc_t head,
	output logic               empty
);
	import phg_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	phg_desc_t         entries_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full  = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(a_queue_overflow, clk, arst_n, push && full, "push into full queue")
	`ASSERT_NEVER(a_queue_underflow, clk, arst_n, pop && empty, "pop from empty queue")

endmodule

@@ rtl/core/phg_back.sv @@
// ----------------------------------------------------------------------------
// PES header generator byte sequencer
// Walks one descriptor byte by byte into the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module phg_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  phg_pkg::phg_desc_t           head,
	input  logic                         empty,
	output logic                         pop,
	input  logic [phg_pkg::BYTE_W-1:0]   sid,
	input  logic [phg_pkg::BYTE_W-1:0]   ext_sid,
	output logic                         hdr_valid,
	input  logic                         hdr_stall,
	output logic [phg_pkg::BYTE_W-1:0]   header_byte,
	output logic                         last_byte
);
	import phg_pkg::*;

	logic [POS_W-1:0]    pos_q;
	logic                hdr_valid_q;
	logic [BYTE_W-1:0]   byte_q;
	logic                last_q;

	logic                emit;
	logic                is_last;
	logic [TOTAL_W-1:0]  p;
	logic [TOTAL_W-1:0]  stamp_end;
	logic [TOTAL_W-1:0]  ext_end;
	logic [TOTAL_W-1:0]  off;
	logic                second;
	logic [2:0]          k;
	logic [3:0]          prefix;
	logic [BYTE_W-1:0]   flags;
	logic [BYTE_W-1:0]   next_byte;

	assign emit    = !empty && (!hdr_valid_q || !hdr_stall);
	assign p       = TOTAL_W'(pos_q);
	assign is_last = ((p + 1'b1) == head.total);
	assign pop     = emit && is_last;

	always_comb begin
		unique case (head.ts_mode)
			TS_BOTH: stamp_end = FULL_BASE + STAMP_LEN + STAMP_LEN;
			TS_PTS:  stamp_end = FULL_BASE + STAMP_LEN;
			default: stamp_end = FULL_BASE;
		endcase
		ext_end = head.ext ? stamp_end + EXT_LEN : stamp_end;
		off     = p - FULL_BASE;
		second  = (off >= STAMP_LEN);
		k       = second ? 3'(off - STAMP_LEN) : 3'(off);
		if (head.ts_mode == TS_BOTH) begin
			prefix = second ? PREFIX_DTS : PREFIX_PTS;
		end else begin
			prefix = PREFIX_PTS_ONLY;
		end
		unique case (head.ts_mode)
			TS_BOTH: flags = FLAGS_BOTH;
			TS_PTS:  flags = FLAGS_PTS;
			default: flags = '0;
		endcase
		if (head.ext) begin
			flags = flags | FLAGS_EXT;
		end
	end

	always_comb begin
		if (!head.full || (p < FULL_BASE)) begin
			unique case (p)
				7'd0: next_byte = START_BYTE0;
				7'd1: next_byte = START_BYTE1;
				7'd2: next_byte = START_BYTE2;
				7'd3: next_byte = sid;
				7'd4: next_byte = head.length_field[15:8];
				7'd5: next_byte = head.length_field[7:0];
				7'd6: next_byte = FLAG1_BASE | (head.align ? FLAG1_ALIGN : '0);
				7'd7: next_byte = flags;
				7'd8: next_byte = BYTE_W'(head.total - FULL_BASE);
				default: next_byte = PAD_BYTE;
			endcase
		end else if (p < stamp_end) begin
			next_byte = stamp_byte(prefix, second ? head.dts : head.pts, k);
		end else if (p < ext_end) begin
			priority if (p == stamp_end) begin
				next_byte = EXT_BYTE0;
			end else if (p == stamp_end + 1'b1) begin
				next_byte = EXT_BYTE1;
			end else begin
				next_byte = ext_sid;
			end
		end else begin
			next_byte = PAD_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			hdr_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				hdr_valid_q <= 1'b1;
				pos_q       <= is_last ? '0 : pos_q + 1'b1;
			end else if (!hdr_stall) begin
				hdr_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= next_byte;
			last_q <= is_last;
		end
	end

	assign hdr_valid   = hdr_valid_q;
	assign header_byte = byte_q;
	assign last_byte   = last_q;

	`ASSERT_CLK(a_pos_restart, clk, arst_n, pop |=> (pos_q == '0), "position not cleared")
	`ASSERT_CLK(a_pos_bound, clk, arst_n, !empty |-> (p < head.total), "position past header end")

endmodule

@@ rtl/core/pes_header_generator.sv @@
// When idle, a request passes the descriptor queue and then the output register before
// its first header byte is valid. Header bytes leave at one per cycle while hdr_stall is
// low; headers are 6 bytes short, 9 to 64 full, 19 or more with PTS and DTS.
// Requests queue up to QUEUE_DEPTH deep and follow with no gap between headers.
// Reset: asynchronous active low; clears control state and sets registers to defaults.
// ----------------------------------------------------------------------------
// PES header generator
// Writes the MPEG-2 PES header for each request, one byte per transaction.
// ----------------------------------------------------------------------------
module pes_header_generator #(
	parameter int QUEUE_DEPTH = phg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [phg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [phg_pkg::BYTE_W-1:0]     cfg_data,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [phg_pkg::SIZE_W-1:0]     payload_size,
	input  logic [phg_pkg::TS_W-1:0]       pts,
	input  logic                           pts_valid,
	input  logic [phg_pkg::TS_W-1:0]       dts,
	input  logic                           dts_valid,
	output logic                           hdr_valid,
	input  logic                           hdr_stall,
	output logic [phg_pkg::BYTE_W-1:0]     header_byte,
	output logic                           last_byte
);
	import phg_pkg::*;

	logic [BYTE_W-1:0]   sid_q;
	logic [OPT_W-1:0]    header_options_q;
	logic [BYTE_W-1:0]   ext_sid_q;
	logic [FIXED_W-1:0]  fixed_length_q;
	logic                is_video_q;

	logic                push;
	logic                pop;
	logic                full;
	logic                empty;
	phg_desc_t           push_desc;
	phg_desc_t           head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sid_q            <= 8'hE0;
			header_options_q <= 3'd1;
			ext_sid_q        <= '0;
			fixed_length_q   <= '0;
			is_video_q       <= 1'b1;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_SID:          sid_q            <= cfg_data;
				CFG_HEADER_OPTS:  header_options_q <= cfg_data[OPT_W-1:0];
				CFG_EXT_SID:      ext_sid_q        <= cfg_data;
				CFG_FIXED_LENGTH: fixed_length_q   <= cfg_data[FIXED_W-1:0];
				CFG_IS_VIDEO:     is_video_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	phg_front u_front (
		.req_valid           (req_valid),
		.req_stall           (req_stall),
		.payload_size        (payload_size),
		.pts                 (pts),
		.pts_valid           (pts_valid),
		.dts                 (dts),
		.dts_valid           (dts_valid),
		.header_options      (header_options_q),
		.fixed_header_length (fixed_length_q),
		.is_video            (is_video_q),
		.queue_full          (full),
		.push                (push),
		.desc                (push_desc)
	);

	phg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	phg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.sid         (sid_q),
		.ext_sid     (ext_sid_q),
		.hdr_valid   (hdr_valid),
		.hdr_stall   (hdr_stall),
		.header_byte (header_byte),
		.last_byte   (last_byte)
	);

endmodule

@@ verif/pes_header_checker.sv @@
// ----------------------------------------------------------------------------
// PES header generator checker
// Watches the register port and both channels, predicts the header bytes of
// every accepted request and compares each accepted output transaction with
// the oldest predicted byte.
// ----------------------------------------------------------------------------
module pes_header_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [phg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [phg_pkg::BYTE_W-1:0]    cfg_data,
	input  logic                          req_valid,
	input  logic                          req_stall,
	input  logic [phg_pkg::SIZE_W-1:0]    payload_size,
	input  logic [phg_pkg::TS_W-1:0]      pts,
	input  logic                          pts_valid,
	input  logic [phg_pkg::TS_W-1:0]      dts,
	input  logic                          dts_valid,
	input  logic                          hdr_valid,
	input  logic                          hdr_stall,
	input  logic [phg_pkg::BYTE_W-1:0]    header_byte,
	input  logic                          last_byte,
	output int                            fail_count,
	output int                            beats_due
);
	import phg_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] hbyte;
		logic              last;
	} hdr_beat_t;

	hdr_beat_t header_bytes_due[$];
	hdr_beat_t due;

	logic [BYTE_W-1:0]  sid_reg;
	logic [OPT_W-1:0]   opts_reg;
	logic [BYTE_W-1:0]  ext_id_reg;
	logic [FIXED_W-1:0] fixed_reg;
	logic               video_reg;

	int emit_pos;
	int emit_total;

	function automatic void emit_byte(input logic [BYTE_W-1:0] b);
		hdr_beat_t beat;
		beat.hbyte = b;
		beat.last  = (emit_pos + 1 >= emit_total);
		header_bytes_due.push_back(beat);
		emit_pos++;
	endfunction

	function automatic void emit_stamp(input logic [3:0] prefix, input logic [TS_W-1:0] ts);
		emit_byte({prefix, ts[32:30], 1'b1});
		emit_byte(ts[29:22]);
		emit_byte({ts[21:15], 1'b1});
		emit_byte(ts[14:7]);
		emit_byte({ts[6:0], 1'b1});
	endfunction

	function automatic void build_pes_header(input logic [SIZE_W-1:0] size,
			input logic [TS_W-1:0] p, input logic pv, input logic [TS_W-1:0] d,
			input logic dv);
		ts_mode_t          mode;
		int                total;
		int                span;
		logic [LEN_W-1:0]  len_field;
		logic [BYTE_W-1:0] flags;
		logic              full;
		logic              align;
		logic              ext;
		full  = opts_reg[OPT_FULL];
		align = opts_reg[OPT_ALIGN];
		ext   = opts_reg[OPT_EXT];
		if (pv && dv && p != d)
			mode = TS_BOTH;
		else if (pv)
			mode = TS_PTS;
		else
			mode = TS_NONE;
		total = 6;
		if (full) begin
			total = 9;
			if (mode == TS_BOTH)
				total += 10;
			else if (mode == TS_PTS)
				total += 5;
			if (ext)
				total += 3;
			if (fixed_reg != 0 && total <= int'(fixed_reg) + 9) begin
				total = int'(fixed_reg) + 9;
				if (total > MAX_HEADER_BYTES)
					total = MAX_HEADER_BYTES;
			end
		end
		span = int'(size) + total - 6;
		if (size == 0 || (video_reg && span > 32'hFFFF))
			len_field = '0;
		else
			len_field = span[LEN_W-1:0];

		emit_total = total;
		emit_pos   = 0;
		emit_byte(START_BYTE0);
		emit_byte(START_BYTE1);
		emit_byte(START_BYTE2);
		emit_byte(sid_reg);
		emit_byte(len_field[15:8]);
		emit_byte(len_field[7:0]);
		if (full) begin
			emit_byte(align ? (FLAG1_BASE | FLAG1_ALIGN) : FLAG1_BASE);
			flags = '0;
			if (mode == TS_BOTH)
				flags = flags | FLAGS_BOTH;
			else if (mode == TS_PTS)
				flags = flags | FLAGS_PTS;
			if (ext)
				flags = flags | FLAGS_EXT;
			emit_byte(flags);
			emit_byte(8'(total - 9));
			if (mode == TS_BOTH) begin
				emit_stamp(PREFIX_PTS, p);
				emit_stamp(PREFIX_DTS, d);
			end else if (mode == TS_PTS) begin
				emit_stamp(PREFIX_PTS_ONLY, p);
			end
			if (ext) begin
				emit_byte(EXT_BYTE0);
				emit_byte(EXT_BYTE1);
				emit_byte(ext_id_reg);
			end
			while (emit_pos < total)
				emit_byte(PAD_BYTE);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sid_reg    = 8'hE0;
			opts_reg   = 3'd1;
			ext_id_reg = 8'h00;
			fixed_reg  = '0;
			video_reg  = 1'b1;
			header_bytes_due.delete();
			fail_count = 0;
			beats_due  = 0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					CFG_SID:          sid_reg    = cfg_data;
					CFG_HEADER_OPTS:  opts_reg   = cfg_data[OPT_W-1:0];
					CFG_EXT_SID:      ext_id_reg = cfg_data;
					CFG_FIXED_LENGTH: fixed_reg  = cfg_data[FIXED_W-1:0];
					CFG_IS_VIDEO:     video_reg  = cfg_data[0];
					default: ;
				endcase
			end
			// pop before push: a request never produces a byte on its own edge
			if (hdr_valid && !hdr_stall) begin
				if (header_bytes_due.size() == 0) begin
					$display("%0t: unexpected header byte: expected none, actual %02h last %0b",
						$time, header_byte, last_byte);
					fail_count++;
				end else begin
					due = header_bytes_due.pop_front();
					if (header_byte !== due.hbyte) begin
						$display("%0t: header_byte mismatch: expected %02h, actual %02h",
							$time, due.hbyte, header_byte);
						fail_count++;
					end
					if (last_byte !== due.last) begin
						$display("%0t: last_byte mismatch: expected %0b, actual %0b",
							$time, due.last, last_byte);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall)
				build_pes_header(payload_size, pts, pts_valid, dts, dts_valid);
			beats_due = header_bytes_due.size();
		end
	end

endmodule

@@ verif/tb_pes_header_generator.sv @@
// ----------------------------------------------------------------------------
// PES header generator testbench
// Drives header requests under a series of register settings, with random
// idle bursts on both channels and one long output hold-off; the checker
// predicts and compares every header byte.
// ----------------------------------------------------------------------------
module tb_pes_header_generator;
	import phg_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;
	logic                 req_valid;
	logic                 req_stall;
	logic [SIZE_W-1:0]    payload_size;
	logic [TS_W-1:0]      pts;
	logic                 pts_valid;
	logic [TS_W-1:0]      dts;
	logic                 dts_valid;
	logic                 hdr_valid;
	logic                 hdr_stall;
	logic [BYTE_W-1:0]    header_byte;
	logic                 last_byte;

	int fail_count;
	int beats_due;
	bit idle_on;
	bit hold_off;

	pes_header_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.payload_size (payload_size),
		.pts          (pts),
		.pts_valid    (pts_valid),
		.dts          (dts),
		.dts_valid    (dts_valid),
		.hdr_valid    (hdr_valid),
		.hdr_stall    (hdr_stall),
		.header_byte  (header_byte),
		.last_byte    (last_byte)
	);

	pes_header_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.payload_size (payload_size),
		.pts          (pts),
		.pts_valid    (pts_valid),
		.dts          (dts),
		.dts_valid    (dts_valid),
		.hdr_valid    (hdr_valid),
		.hdr_stall    (hdr_stall),
		.header_byte  (header_byte),
		.last_byte    (last_byte),
		.fail_count   (fail_count),
		.beats_due    (beats_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("tb_pes_header_generator: errors");
		$finish;
	end

	// output side: random stall bursts, plus one long hold-off on request
	initial begin
		hdr_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				hdr_stall <= 1'b1;
				repeat (300) @(negedge clk);
				hdr_stall <= 1'b0;
				hold_off = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				hdr_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				hdr_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= data;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic apply_config(input logic [7:0] sid, input logic [2:0] opts,
			input logic [7:0] ext_id, input logic [5:0] fixed, input logic vid);
		@(negedge clk);
		req_valid <= 1'b0;
		// hold until every predicted byte has left
		wait (beats_due == 0);
		repeat (4) @(negedge clk);
		write_reg(CFG_SID, sid);
		write_reg(CFG_HEADER_OPTS, {5'd0, opts});
		write_reg(CFG_EXT_SID, ext_id);
		write_reg(CFG_FIXED_LENGTH, {2'd0, fixed});
		write_reg(CFG_IS_VIDEO, {7'd0, vid});
	endtask

	task automatic offer_request(input logic [SIZE_W-1:0] size, input logic [TS_W-1:0] p,
			input logic pv, input logic [TS_W-1:0] d, input logic dv);
		logic stalled;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_valid    <= 1'b1;
		payload_size <= size;
		pts          <= p;
		pts_valid    <= pv;
		dts          <= d;
		dts_valid    <= dv;
		// sample the stall ahead of the edge that it governs
		stalled = req_stall;
		@(posedge clk);
		while (stalled) begin
			@(negedge clk);
			stalled = req_stall;
			@(posedge clk);
		end
	endtask

	task automatic random_request();
		logic [SIZE_W-1:0] size;
		logic [TS_W-1:0]   p;
		logic [TS_W-1:0]   d;
		logic              pv;
		logic              dv;
		case ($urandom_range(0, 7))
			0:       size = '0;
			1:       size = '1;
			2, 3:    size = SIZE_W'($urandom_range(1, 300));
			4, 5:    size = SIZE_W'($urandom_range(65450, 65535));
			default: size = SIZE_W'($urandom);
		endcase
		p = TS_W'({$urandom, $urandom});
		d = TS_W'({$urandom, $urandom});
		if ($urandom_range(0, 15) == 0)
			p = '1;
		if ($urandom_range(0, 15) == 0)
			d = '0;
		case ($urandom_range(0, 7))
			0, 1, 2, 3: begin pv = 1'b1; dv = 1'b1; end
			4:          begin pv = 1'b1; dv = 1'b1; d = p; end
			5:          begin pv = 1'b1; dv = 1'b0; end
			6:          begin pv = 1'b0; dv = 1'b1; end
			default:    begin pv = 1'b0; dv = 1'b0; end
		endcase
		offer_request(size, p, pv, d, dv);
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		req_valid    = 1'b0;
		payload_size = '0;
		pts          = '0;
		pts_valid    = 1'b0;
		dts          = '0;
		dts_valid    = 1'b0;
		idle_on      = 1'b1;
		hold_off     = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: full header, video
		offer_request(24'd0, 33'd0, 1'b1, 33'd1, 1'b1);
		offer_request(24'hFFFFFF, '1, 1'b1, 33'd0, 1'b1);
		offer_request(24'd100, 33'd5, 1'b1, 33'd5, 1'b1);
		offer_request(24'd1, 33'h0AAAAAAAA, 1'b0, 33'h155555555, 1'b1);
		offer_request(24'd65522, 33'h123456789, 1'b1, 33'h0FEDCBA98, 1'b1);
		offer_request(24'd65523, 33'h123456789, 1'b1, 33'h0FEDCBA98, 1'b1);
		offer_request(24'd65530, '1, 1'b1, '1, 1'b0);

		// everything at maximum, non-video wrap
		apply_config(8'hFF, 3'd7, 8'hFF, 6'd55, 1'b0);
		offer_request(24'hFFFFFF, '1, 1'b1, 33'd0, 1'b1);
		offer_request(24'd65523, 33'd77, 1'b1, 33'd78, 1'b1);
		offer_request(24'd4000, 33'd0, 1'b0, 33'd0, 1'b0);

		// short header: alignment, extension and fixed length ignored
		apply_config(8'h00, 3'd6, 8'h3C, 6'd1, 1'b0);
		offer_request(24'd0, 33'd0, 1'b0, 33'd0, 1'b0);
		offer_request(24'hFFFFFF, 33'd9, 1'b1, 33'd3, 1'b1);
		offer_request(24'd65535, '1, 1'b1, 33'd0, 1'b0);

		// fixed length shorter than needed, and padding
		apply_config(8'hBD, 3'd5, 8'h5A, 6'd5, 1'b1);
		offer_request(24'd500, 33'h1F0F0F0F0, 1'b1, 33'h00F0F0F0F, 1'b1);
		offer_request(24'd500, 33'd0, 1'b0, 33'd0, 1'b1);
		offer_request(24'd500, 33'h100000000, 1'b1, 33'h100000000, 1'b1);

		// fixed length exactly equal to the needed length with PTS and DTS, else padding
		apply_config(8'hC0, 3'd3, 8'h00, 6'd10, 1'b1);
		offer_request(24'd65516, 33'd0, 1'b0, 33'd0, 1'b0);
		offer_request(24'd65517, 33'd1, 1'b1, 33'd2, 1'b1);

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0)
				apply_config(8'h00, 3'd0, 8'h00, 6'd0, 1'b0);
			else if (ph == 1)
				apply_config(8'hFF, 3'd7, 8'hFF, 6'd55, 1'b1);
			else
				apply_config(8'($urandom), 3'($urandom_range(0, 7)), 8'($urandom),
					($urandom_range(0, 2) == 0) ? 6'd0 : 6'($urandom_range(0, 55)),
					1'($urandom_range(0, 1)));
			if (ph == 2)
				hold_off = 1'b1;
			if (ph == 7)
				idle_on = 1'b0;
			for (int n = 0; n < 55; n++)
				random_request();
		end
		@(negedge clk);
		req_valid <= 1'b0;

		wait (beats_due == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && beats_due == 0)
			$display("tb_pes_header_generator: clean");
		else
			$display("tb_pes_header_generator: errors");
		$finish;
	end

endmodule
